>>> rtl/core/xppi_pkg.sv
// Shared types and constants for the XOR parity packet inserter.
`timescale 1ns / 1ps

package xppi_pkg;

    // Byte position within a packet and finished packets within a group.
    localparam int POS_W       = 4;
    localparam int PIG_W       = 2;
    localparam int STORE_DEPTH = 16;

    // Packet count at which a group of three data packets is complete.
    localparam logic [PIG_W-1:0] GROUP_FULL = 2'd3;

    // Kind of byte sent into the coded stream.
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_PAD    = 2'd1,
        KIND_PARITY = 2'd2
    } kind_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_PAD,
        ST_PARITY
    } state_t;

    // Input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_word_t;

    // Output word.
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       run_last;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  emit;
        kind_t kind;
    } dp_cmd_t;

    // Status from the datapath to the controller, valid for the byte on show.
    typedef struct packed {
        logic group_full;
        logic more_pad;
    } dp_status_t;

endpackage

>>> rtl/core/xppi_ctrl.sv
// Controller state machine for the XOR parity packet inserter.
`timescale 1ns / 1ps

module xppi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  xppi_pkg::dp_status_t status,
    output xppi_pkg::dp_cmd_t    cmd
);
    import xppi_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: after each byte leaves, parity takes precedence over padding.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA, ST_PAD, ST_PARITY:
            begin
                if (!out_stall)
                begin
                    if (status.group_full)
                    begin
                        state_next = ST_PARITY;
                    end
                    else if (status.more_pad)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: handshakes and the datapath command.
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        cmd.load  = 1'b0;
        cmd.emit  = 1'b0;
        cmd.kind  = KIND_DATA;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DATA:
            begin
                out_valid = 1'b1;
                cmd.emit  = !out_stall;
                cmd.kind  = KIND_DATA;
            end
            ST_PAD:
            begin
                out_valid = 1'b1;
                cmd.emit  = !out_stall;
                cmd.kind  = KIND_PAD;
            end
            ST_PARITY:
            begin
                out_valid = 1'b1;
                cmd.emit  = !out_stall;
                cmd.kind  = KIND_PARITY;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // The last byte of a run returns the controller to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !status.group_full && !status.more_pad)
        |=> (state_reg == ST_IDLE))
        else $error("run did not end after its last byte");

    // An accepted word is always sent on next.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DATA))
        else $error("accepted word not presented");

    // A stalled byte keeps the controller where it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(state_reg))
        else $error("state moved while output stalled");
`endif

endmodule

>>> rtl/core/xppi_dpath.sv
// Datapath for the XOR parity packet inserter: counters, parity store, output word.
`timescale 1ns / 1ps

module xppi_dpath #(
    parameter int PACKET_BYTES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  xppi_pkg::in_word_t   in_data,
    input  xppi_pkg::dp_cmd_t    cmd,
    output xppi_pkg::dp_status_t status,
    output xppi_pkg::out_word_t  out_data
);
    import xppi_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [PIG_W-1:0] pig_reg;
    logic [PIG_W-1:0] pig_next;
    logic [7:0]       data_reg;
    logic [7:0]       data_next;
    logic             final_reg;
    logic             final_next;
    logic [7:0]       parity_reg [STORE_DEPTH];
    logic [7:0]       parity_next [STORE_DEPTH];

    logic             wrap;
    logic [POS_W-1:0] pos_adv;
    logic [PIG_W-1:0] pig_adv;
    logic [7:0]       byte_sel;

    // Counter values after the byte on show has left.
    always_comb
    begin
        wrap    = (pos_reg == LAST_POS);
        pos_adv = wrap ? '0 : pos_reg + POS_W'(1);
        case (cmd.kind)
            KIND_PARITY:
            begin
                pig_adv = wrap ? '0 : pig_reg;
            end
            default:
            begin
                pig_adv = wrap ? pig_reg + PIG_W'(1) : pig_reg;
            end
        endcase
    end

    // Status: a full group calls for parity, an open message end for padding.
    always_comb
    begin
        status.group_full = (pig_adv == GROUP_FULL);
        status.more_pad   = final_reg && ((pos_adv != '0) || (pig_adv != '0));
    end

    // Byte on show.
    always_comb
    begin
        case (cmd.kind)
            KIND_DATA:   byte_sel = data_reg;
            KIND_PAD:    byte_sel = 8'h00;
            KIND_PARITY: byte_sel = parity_reg[pos_reg];
            default:     byte_sel = 8'h00;
        endcase
        out_data.out_byte = byte_sel;
        out_data.kind     = cmd.kind;
        out_data.run_last = !status.group_full && !status.more_pad;
    end

    // Next values: data and padding fold into the parity, parity readout clears it.
    always_comb
    begin
        pos_next    = pos_reg;
        pig_next    = pig_reg;
        data_next   = data_reg;
        final_next  = final_reg;
        parity_next = parity_reg;
        if (cmd.load)
        begin
            data_next  = in_data.data_byte;
            final_next = in_data.is_final;
        end
        if (cmd.emit)
        begin
            pos_next = pos_adv;
            pig_next = pig_adv;
            if (cmd.kind == KIND_PARITY)
            begin
                parity_next[pos_reg] = 8'h00;
            end
            else
            begin
                parity_next[pos_reg] = parity_reg[pos_reg] ^ byte_sel;
            end
        end
    end

    // Control registers and parity store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            pig_reg <= '0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                parity_reg[i] <= 8'h00;
            end
        end
        else
        begin
            pos_reg    <= pos_next;
            pig_reg    <= pig_next;
            parity_reg <= parity_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        final_reg <= final_next;
    end

`ifndef ASSERT_OFF
    // A new word never arrives while a parity packet is still owed.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (pig_reg != GROUP_FULL))
        else $error("word accepted with parity pending");

    // Parity bytes go out only for a full group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.kind == KIND_PARITY)) |-> (pig_reg == GROUP_FULL))
        else $error("parity sent for an incomplete group");

    // Padding is sent only at the end of a message.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.kind == KIND_PAD)) |-> final_reg)
        else $error("padding outside message end");
`endif

endmodule

>>> rtl/core/xor_parity_packet_inserter_unit.sv
// Top level of the XOR parity packet inserter.
`timescale 1ns / 1ps

// Passes message bytes through and adds one XOR parity packet after every three
// data packets of PACKET_BYTES bytes. On the word marked final, a partial packet
// is padded with zeros, the group is filled with zero packets and the parity
// follows; the block then starts clean for the next message. Each input word
// is first accepted and then presented as its own byte. Every padding or parity
// byte it causes follows on the single output port, which sends one byte per
// cycle while out_stall is low; a word causes from 1 to 64 result bytes in all.
// The parity store sits in flip-flops that reset clears at once; there is no
// clearing pass.
module xor_parity_packet_inserter_unit #(
    parameter int PACKET_BYTES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  xppi_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output xppi_pkg::out_word_t out_data
);
    import xppi_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller.
    xppi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    xppi_dpath #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
